// ===== rtl/bidirectional_ring_mailbox_top_macros.svh =====
// Assertion macros shared by the mailbox RTL.
`ifndef BIDIRECTIONAL_RING_MAILBOX_TOP_MACROS_SVH
`define BIDIRECTIONAL_RING_MAILBOX_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication on i_clk, off during reset.
`define BRM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Next-cycle implication on i_clk, off during reset.
`define BRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define BRM_ASSERT_IMPL(label, ante, cons)
`define BRM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/brm_pkg.sv =====
package brm_pkg;

    localparam int DEPTH    = 64;
    localparam int MSG_BITS = 64;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int FREE_W   = 6;
    localparam int FREE_MAX = (1 << FREE_W) - 1;
    localparam int DIFF_W   = (PTR_W + 1 > FREE_W) ? PTR_W + 1 : FREE_W + 1;

    // opcodes
    localparam logic [2:0] OP_SEND  = 3'd0;
    localparam logic [2:0] OP_GET   = 3'd1;
    localparam logic [2:0] OP_ACT   = 3'd2;
    localparam logic [2:0] OP_RST   = 3'd3;
    localparam logic [2:0] OP_SLEEP = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOTCONN = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_BUSY    = 3'd4;

    typedef struct packed {
        logic        side;
        logic [2:0]  opcode;
        logic [63:0] payload;
    } t_req;

    typedef struct packed {
        logic [2:0]        status;
        logic [63:0]       message_out;
        logic [FREE_W-1:0] free_slots;
        logic [31:0]       sent_count;
        logic [31:0]       received_count;
        logic [31:0]       peer_sleep_seq;
    } t_rsp;

    // per-ring control from the sequencer
    typedef struct packed {
        logic                rd_en;
        logic                push;
        logic                pop;
        logic                clear;
        logic                seq_wr;
        logic [MSG_BITS-1:0] wr_data;
        logic [31:0]         seq;
    } t_ring_ctl;

    // per-ring status; free_slots and note_seq are post-update values
    typedef struct packed {
        logic                empty;
        logic                full;
        logic [MSG_BITS-1:0] rd_data;
        logic [FREE_W-1:0]   free_slots;
        logic [31:0]         note_seq;
    } t_ring_sts;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // (head + DEPTH - tail - 1) mod DEPTH, capped at FREE_MAX
    function automatic logic [FREE_W-1:0] ring_free(input logic [PTR_W-1:0] h,
                                                     input logic [PTR_W-1:0] t);
        logic [DIFF_W-1:0] hx;
        logic [DIFF_W-1:0] tx;
        logic [DIFF_W-1:0] d;
        hx = DIFF_W'(h);
        tx = DIFF_W'(t);
        if (h > t) begin
            d = hx - tx - 1'b1;
        end else begin
            d = hx + DIFF_W'(DEPTH) - tx - 1'b1;
        end
        return (d > DIFF_W'(FREE_MAX)) ? FREE_W'(FREE_MAX) : d[FREE_W-1:0];
    endfunction

endpackage

// ===== rtl/brm_ring.sv =====
`include "bidirectional_ring_mailbox_top_macros.svh"

module brm_ring (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  brm_pkg::t_ring_ctl i_ctl,
    output brm_pkg::t_ring_sts o_sts
);

    logic [brm_pkg::MSG_BITS-1:0] r_mem [brm_pkg::DEPTH];
    logic [brm_pkg::MSG_BITS-1:0] r_rd_data;
    logic [brm_pkg::PTR_W-1:0]    r_head, n_head;
    logic [brm_pkg::PTR_W-1:0]    r_tail, n_tail;
    logic [brm_pkg::CNT_W-1:0]    r_count, n_count;
    logic [31:0]                  r_seq, n_seq;

    // slot store: write at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_tail] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_seq   = r_seq;
        if (i_ctl.clear) begin
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
            n_seq   = '0;
        end else begin
            if (i_ctl.push) begin
                n_tail  = brm_pkg::ptr_inc(r_tail);
                n_count = r_count + 1'b1;
            end
            if (i_ctl.pop) begin
                n_head  = brm_pkg::ptr_inc(r_head);
                n_count = r_count - 1'b1;
            end
            if (i_ctl.seq_wr) begin
                n_seq = i_ctl.seq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_seq   <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_seq   <= n_seq;
        end
    end

    // used flag of head slot == count nonzero; of tail slot == ring full
    assign o_sts.empty      = (r_count == '0);
    assign o_sts.full       = (r_count == brm_pkg::CNT_W'(brm_pkg::DEPTH));
    assign o_sts.rd_data    = r_rd_data;
    assign o_sts.free_slots = brm_pkg::ring_free(n_head, n_tail);
    assign o_sts.note_seq   = n_seq;

    `BRM_ASSERT_IMPL(a_count_range, 1'b1, r_count <= brm_pkg::CNT_W'(brm_pkg::DEPTH))
    `BRM_ASSERT_IMPL(a_no_push_pop, i_ctl.push, !i_ctl.pop)
    `BRM_ASSERT_IMPL(a_ptr_match, o_sts.empty || o_sts.full, r_head == r_tail)

endmodule

// ===== rtl/bidirectional_ring_mailbox_top.sv =====
// Channel   | Ports                  | Handshake
// ----------+------------------------+----------------------------------------
// request   | i_req (t_req)          | taken when start && !busy
// result    | o_rsp (t_rsp)          | o_done high one cycle, no back-pressure
//
// A request is taken, then executed: taking it reads the head slot of both rings
// from their memories into a registered read, and the busy step checks flags and
// counters and writes pointers, counters and, on a send, the tail slot.
// The result is registered and shows with o_done; busy is low then, so a new
// request can start while a result is shown, but none is taken while busy.
// The registered slot-memory read lies in front of the update.
// Reset (i_rst_n low, synchronous) empties both rings and drops both sides.
// The receiver cannot stall; each result is shown exactly once.
`include "bidirectional_ring_mailbox_top_macros.svh"

module bidirectional_ring_mailbox_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  brm_pkg::t_req i_req,
    output logic          o_done,
    output brm_pkg::t_rsp o_rsp
);

    logic               w_accept;
    logic               r_busy;
    logic               r_done;
    brm_pkg::t_req      r_req;
    brm_pkg::t_rsp      r_rsp, n_rsp;

    // per-side state, index is the side bit
    logic [1:0]         r_active, n_active;
    logic [31:0]        r_sent [2];
    logic [31:0]        n_sent [2];
    logic [31:0]        r_recv [2];
    logic [31:0]        n_recv [2];

    brm_pkg::t_ring_ctl fwd_ctl, rev_ctl;
    brm_pkg::t_ring_sts fwd_sts, rev_sts;
    brm_pkg::t_ring_sts tx_sts, rx_sts;

    logic               w_side;
    logic [2:0]         w_status;
    logic               w_send_ok;
    logic               w_get_ok;
    logic               w_clear;
    logic               w_sleep;

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;

    // fwd ring carries side 0 -> side 1, rev ring side 1 -> side 0
    brm_ring u_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fwd_ctl),
        .o_sts   (fwd_sts)
    );

    brm_ring u_rev (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rev_ctl),
        .o_sts   (rev_sts)
    );

    assign w_side = r_req.side;
    assign tx_sts = w_side ? rev_sts : fwd_sts;
    assign rx_sts = w_side ? fwd_sts : rev_sts;

    // decode and check in the execute cycle
    always_comb begin
        w_status  = brm_pkg::ST_OK;
        w_send_ok = 1'b0;
        w_get_ok  = 1'b0;
        w_clear   = 1'b0;
        w_sleep   = 1'b0;
        n_active  = r_active;
        n_sent    = r_sent;
        n_recv    = r_recv;
        case (r_req.opcode)
            brm_pkg::OP_SEND: begin
                if (!r_active[w_side]) begin
                    w_status = brm_pkg::ST_NOTCONN;
                end else if (tx_sts.full) begin
                    w_status = brm_pkg::ST_FULL;
                end else begin
                    w_send_ok        = 1'b1;
                    n_sent[w_side]   = r_sent[w_side] + 32'd1;
                end
            end
            brm_pkg::OP_GET: begin
                if (!r_active[w_side]) begin
                    w_status = brm_pkg::ST_NOTCONN;
                end else if (rx_sts.empty) begin
                    w_status = brm_pkg::ST_EMPTY;
                end else begin
                    w_get_ok         = 1'b1;
                    n_recv[w_side]   = r_recv[w_side] + 32'd1;
                end
            end
            brm_pkg::OP_ACT: begin
                if (r_active[w_side]) begin
                    w_status = brm_pkg::ST_BUSY;
                end else begin
                    n_active[w_side] = 1'b1;
                end
            end
            brm_pkg::OP_RST: begin
                w_clear          = 1'b1;
                n_active[w_side] = 1'b0;
                n_sent[w_side]   = '0;
                n_recv[w_side]   = '0;
            end
            brm_pkg::OP_SLEEP: begin
                w_sleep = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // ring commands; head read issued as the request is taken
    always_comb begin
        fwd_ctl.rd_en   = w_accept;
        fwd_ctl.push    = r_busy && w_send_ok && !w_side;
        fwd_ctl.pop     = r_busy && w_get_ok && w_side;
        fwd_ctl.clear   = r_busy && w_clear;
        fwd_ctl.seq_wr  = r_busy && w_sleep && w_side;
        fwd_ctl.wr_data = r_req.payload[brm_pkg::MSG_BITS-1:0];
        fwd_ctl.seq     = r_recv[w_side];

        rev_ctl.rd_en   = w_accept;
        rev_ctl.push    = r_busy && w_send_ok && w_side;
        rev_ctl.pop     = r_busy && w_get_ok && !w_side;
        rev_ctl.clear   = r_busy && w_clear;
        rev_ctl.seq_wr  = r_busy && w_sleep && !w_side;
        rev_ctl.wr_data = r_req.payload[brm_pkg::MSG_BITS-1:0];
        rev_ctl.seq     = r_recv[w_side];
    end

    always_comb begin
        n_rsp.status         = w_status;
        n_rsp.message_out    = w_get_ok ? 64'(rx_sts.rd_data) : 64'd0;
        n_rsp.free_slots     = tx_sts.free_slots;
        n_rsp.sent_count     = n_sent[w_side];
        n_rsp.received_count = n_recv[w_side];
        n_rsp.peer_sleep_seq = tx_sts.note_seq;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_active  <= '0;
            r_sent[0] <= '0;
            r_sent[1] <= '0;
            r_recv[0] <= '0;
            r_recv[1] <= '0;
        end else begin
            r_busy <= w_accept;
            r_done <= r_busy;
            if (r_busy) begin
                r_active <= n_active;
                r_sent   <= n_sent;
                r_recv   <= n_recv;
            end
        end
    end

    // request and result holding registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        if (r_busy) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    `BRM_ASSERT_NEXT(a_accept_busy, w_accept, r_busy && !r_done)
    `BRM_ASSERT_NEXT(a_busy_done, r_busy, r_done && !r_busy)
    `BRM_ASSERT_IMPL(a_done_idle, r_done, !r_busy)
    `BRM_ASSERT_IMPL(a_msg_ok, r_done && (r_rsp.message_out != '0), r_rsp.status == brm_pkg::ST_OK)

endmodule
